// ===== rtl/lsa_pkg.sv =====
package lsa_pkg;

    typedef struct packed {
        logic [9:0]  left_dist;
        logic [9:0]  right_dist;
        logic [15:0] left_angle;
        logic [15:0] right_angle;
    } req_t;

    typedef struct packed {
        logic signed [16:0] steer_angle;
        logic [1:0]         lane_mode;
        logic               sum_fault;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         mode;
        logic               fault;
        logic signed [17:0] head;
    } ctl_t;

    localparam logic [1:0] MODE_BOTH          = 2'd0;
    localparam logic [1:0] MODE_LEFT_MISSING  = 2'd1;
    localparam logic [1:0] MODE_RIGHT_MISSING = 2'd2;

    localparam logic [1:0] REG_GAIN_K           = 2'd0;
    localparam logic [1:0] REG_SPEED_KMH        = 2'd1;
    localparam logic [1:0] REG_MISSING_SENTINEL = 2'd2;

    localparam logic [15:0] GAIN_K_RESET    = 16'd1024;
    localparam logic [7:0]  SPEED_RESET     = 8'd20;
    localparam logic [9:0]  SENTINEL_RESET  = 10'd160;

    localparam logic signed [19:0] STEER_LIMIT = 20'sd46080;
    localparam logic signed [18:0] HEAD_BIAS   = 19'sd46080;
    localparam logic signed [18:0] HEAD_CENTER = 19'sd23040;
    localparam logic signed [17:0] LAT_CENTER  = 18'sd16384;

    localparam int ATAN_DEPTH = 24;
    localparam logic [22:0] ATAN_DEG_Q16 [ATAN_DEPTH] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,
        23'd57,      23'd29,      23'd14,     23'd7,
        23'd4,       23'd2,       23'd1,      23'd0
    };

endpackage

// ===== rtl/lane_steering_angle.sv =====
// Channel   Handshake          Payload
// request   start / busy       req    (left/right dist, left/right angle)
// result    done (one cycle)   result (steer_angle, lane_mode, sum_fault)
// config    cfg_we             cfg_index, cfg_data
//
// One request per cycle; busy stays low. The pipeline stages are the
// input stage, 16 divider stages, multiply, scale, one stage per CORDIC
// iteration, output stage. The receiver cannot stall; done marks each result
// for one cycle. Reset clears the valid bits and loads the register defaults.
module lane_steering_angle #(
    parameter int CORDIC_ITERS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lsa_pkg::req_t req,
    output logic          done,
    output lsa_pkg::rsp_t result,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import lsa_pkg::*;

    localparam int DIV_BITS = 16;
    localparam int XW       = 38;
    localparam int ZW       = 25;

    logic [15:0] gain_reg;
    logic [7:0]  speed_reg;
    logic [9:0]  sent_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_K_RESET;
            speed_reg <= SPEED_RESET;
            sent_reg  <= SENTINEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_K:           gain_reg  <= cfg_data;
                REG_SPEED_KMH:        speed_reg <= cfg_data[7:0];
                REG_MISSING_SENTINEL: sent_reg  <= cfg_data[9:0];
                default:              ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input stage
    logic [10:0]        sum_next;
    logic [1:0]         mode_next;
    logic signed [18:0] head_wide;
    logic [24:0]        numl_next, numr_next;
    ctl_t               ctl_next;

    always_comb
    begin
        sum_next = {1'b0, req.left_dist} + {1'b0, req.right_dist};
        if (req.left_dist == sent_reg)
            mode_next = MODE_LEFT_MISSING;
        else if (req.right_dist == sent_reg)
            mode_next = MODE_RIGHT_MISSING;
        else
            mode_next = MODE_BOTH;
        case (mode_next)
            MODE_LEFT_MISSING:
                head_wide = HEAD_CENTER - $signed({3'b0, req.right_angle});
            MODE_RIGHT_MISSING:
                head_wide = $signed({3'b0, req.left_angle}) - HEAD_CENTER;
            default:
                head_wide = ($signed({3'b0, req.left_angle}) +
                             $signed({3'b0, req.right_angle}) - HEAD_BIAS) >>> 1;
        endcase
        numl_next = {req.left_dist, 15'b0} + {15'b0, sum_next[10:1]};
        numr_next = {req.right_dist, 15'b0} + {15'b0, sum_next[10:1]};
        ctl_next.valid = start;
        ctl_next.mode  = mode_next;
        ctl_next.fault = (sum_next == 11'd0);
        ctl_next.head  = head_wide[17:0];
    end

    ctl_t        dctl_reg [DIV_BITS+1];
    logic [10:0] dsum_reg [DIV_BITS+1];
    logic [10:0] rl_reg   [DIV_BITS+1];
    logic [10:0] rr_reg   [DIV_BITS+1];
    logic [15:0] ql_reg   [DIV_BITS+1];
    logic [15:0] qr_reg   [DIV_BITS+1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            dctl_reg[0] <= '0;
        else
            dctl_reg[0] <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        dsum_reg[0] <= sum_next;
        rl_reg[0]   <= {2'b0, numl_next[24:16]};
        rr_reg[0]   <= {2'b0, numr_next[24:16]};
        ql_reg[0]   <= numl_next[15:0];
        qr_reg[0]   <= numr_next[15:0];
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_div
        logic [11:0] tl, tr;
        logic        gel, ger;

        always_comb
        begin
            tl  = {rl_reg[k], ql_reg[k][15]};
            tr  = {rr_reg[k], qr_reg[k][15]};
            gel = (tl >= {1'b0, dsum_reg[k]});
            ger = (tr >= {1'b0, dsum_reg[k]});
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
                dctl_reg[k+1] <= '0;
            else
                dctl_reg[k+1] <= dctl_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dsum_reg[k+1] <= dsum_reg[k];
            rl_reg[k+1]   <= gel ? 11'(tl - {1'b0, dsum_reg[k]}) : tl[10:0];
            rr_reg[k+1]   <= ger ? 11'(tr - {1'b0, dsum_reg[k]}) : tr[10:0];
            ql_reg[k+1]   <= {ql_reg[k][14:0], gel};
            qr_reg[k+1]   <= {qr_reg[k][14:0], ger};
        end
    end

    // lateral error and gain product
    logic signed [17:0] lat_wide;
    logic signed [15:0] lat;
    logic signed [32:0] prod_reg;
    ctl_t               mctl_reg;

    always_comb
    begin
        case (dctl_reg[DIV_BITS].mode)
            MODE_LEFT_MISSING:
                lat_wide = LAT_CENTER - $signed({2'b0, qr_reg[DIV_BITS]});
            MODE_RIGHT_MISSING:
                lat_wide = $signed({2'b0, ql_reg[DIV_BITS]}) - LAT_CENTER;
            default:
                lat_wide = ($signed({2'b0, ql_reg[DIV_BITS]}) -
                            $signed({2'b0, qr_reg[DIV_BITS]})) >>> 1;
        endcase
        lat = lat_wide[15:0];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            mctl_reg <= '0;
        else
            mctl_reg <= dctl_reg[DIV_BITS];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, gain_reg}) * lat;
    end

    // CORDIC vectoring
    ctl_t                 cctl_reg [CORDIC_ITERS+1];
    logic signed [XW-1:0] cx_reg   [CORDIC_ITERS+1];
    logic signed [XW-1:0] cy_reg   [CORDIC_ITERS+1];
    logic signed [ZW-1:0] cz_reg   [CORDIC_ITERS+1];

    logic signed [XW-1:0] prod_ext;
    logic [10:0]          speed5;

    always_comb
    begin
        prod_ext = XW'(prod_reg);
        speed5   = {1'b0, speed_reg, 2'b0} + {3'b0, speed_reg};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            cctl_reg[0] <= '0;
        else
            cctl_reg[0] <= mctl_reg;
    end

    always_ff @(posedge clk)
    begin
        cy_reg[0] <= (prod_ext <<< 4) + (prod_ext <<< 1);
        cx_reg[0] <= $signed({2'b0, speed5, 25'b0});
        cz_reg[0] <= '0;
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_cordic
        logic signed [XW-1:0] xs, ys;
        logic signed [ZW-1:0] step;

        always_comb
        begin
            xs   = cx_reg[i] >>> i;
            ys   = cy_reg[i] >>> i;
            step = $signed({{(ZW-23){1'b0}}, ATAN_DEG_Q16[i]});
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
                cctl_reg[i+1] <= '0;
            else
                cctl_reg[i+1] <= cctl_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (cy_reg[i] > 0)
            begin
                cx_reg[i+1] <= cx_reg[i] + ys;
                cy_reg[i+1] <= cy_reg[i] - xs;
                cz_reg[i+1] <= cz_reg[i] + step;
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] - ys;
                cy_reg[i+1] <= cy_reg[i] + xs;
                cz_reg[i+1] <= cz_reg[i] - step;
            end
        end
    end

    // round, add heading, clamp; zero on sum fault
    logic signed [ZW-1:0] zr;
    logic signed [19:0]   steer_wide;
    logic signed [16:0]   steer_next;
    ctl_t                 last;

    always_comb
    begin
        last       = cctl_reg[CORDIC_ITERS];
        zr         = (cz_reg[CORDIC_ITERS] + ZW'(128)) >>> 8;
        steer_wide = 20'(last.head) + 20'(zr);
        if (last.fault)
            steer_next = '0;
        else if (steer_wide > STEER_LIMIT)
            steer_next = STEER_LIMIT[16:0];
        else if (steer_wide < -STEER_LIMIT)
            steer_next = 17'(-STEER_LIMIT);
        else
            steer_next = steer_wide[16:0];
    end

    logic done_reg;
    rsp_t result_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg.steer_angle <= steer_next;
        result_reg.lane_mode   <= last.mode;
        result_reg.sum_fault   <= last.fault;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/lsa_checker.sv =====
module lsa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          busy,
    input logic          done,
    input lsa_pkg::rsp_t result
);
    import lsa_pkg::*;

    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.sum_fault |-> result.steer_angle == 17'sd0)
        else $error("fault with nonzero steer");

    a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.steer_angle <= 17'sd46080 && result.steer_angle >= -17'sd46080))
        else $error("steer out of range");

    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.lane_mode == MODE_BOTH || result.lane_mode == MODE_LEFT_MISSING ||
                  result.lane_mode == MODE_RIGHT_MISSING))
        else $error("bad lane mode");

endmodule

bind lane_steering_angle lsa_checker u_lsa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .done   (done),
    .result (result)
);
